// File: design/packet_class_and_talker_counter_unit_defines.svh
// Assertion macros used by the checker file of this block.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef PACKET_CLASS_AND_TALKER_COUNTER_UNIT_DEFINES_SVH
`define PACKET_CLASS_AND_TALKER_COUNTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pctc_pkg.sv
`timescale 1ns / 1ps
package pctc_pkg;

    localparam int TALKER_ENTRIES_DEF = 16;
    localparam int SLOT_W             = 8;
    localparam int NUM_CLASSES        = 5;

    typedef enum logic [1:0] {
        ACT_TRACK       = 2'd0,
        ACT_READ_TALKER = 2'd1,
        ACT_READ_CLASS  = 2'd2,
        ACT_CLEAR       = 2'd3
    } t_action;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    localparam logic [2:0] CLS_TCP   = 3'd0;
    localparam logic [2:0] CLS_UDP   = 3'd1;
    localparam logic [2:0] CLS_ICMP  = 3'd2;
    localparam logic [2:0] CLS_ARP   = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    localparam logic [1:0] STS_NONE = 2'd0;
    localparam logic [1:0] STS_HIT  = 2'd1;
    localparam logic [1:0] STS_NEW  = 2'd2;
    localparam logic [1:0] STS_FULL = 2'd3;

    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
    localparam logic [15:0] IPV4_MIN_BYTES = ETH_HDR_BYTES + IP_HDR_BYTES;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [3:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  frame_class;
        logic [1:0]  talker_status;
        logic [3:0]  talker_slot;
        logic        entry_valid;
        logic [31:0] entry_address;
        logic [31:0] entry_packets;
        logic [31:0] entry_bytes;
        logic [31:0] class_count;
        logic [31:0] window_packets;
        logic [31:0] window_bytes;
    } t_out_item;

    // Token that walks the talker cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              is_read;
        logic [31:0]       src;
        logic [15:0]       len;
        logic [3:0]        idx;
        logic              hit;
        logic              have_free;
        logic [SLOT_W-1:0] slot;
        logic              ent_valid;
        logic [31:0]       ent_addr;
        logic [31:0]       ent_pkts;
        logic [31:0]       ent_bytes;
    } t_tok;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic              clear;
        logic              alloc;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       src;
        logic [15:0]       len;
    } t_ctl;

    typedef struct packed {
        logic       track;
        logic [2:0] cls;
    } t_class_res;

    function automatic t_class_res classify(input logic [15:0] len,
                                            input logic [15:0] etype,
                                            input logic [7:0]  proto);
        t_class_res res;
        res.track = 1'b0;
        res.cls   = CLS_OTHER;
        if (len < ETH_HDR_BYTES) begin
            res.cls = CLS_OTHER;
        end else if (etype == ETYPE_ARP) begin
            res.cls = CLS_ARP;
        end else if (etype != ETYPE_IPV4 || len < IPV4_MIN_BYTES) begin
            res.cls = CLS_OTHER;
        end else begin
            res.track = 1'b1;
            if (proto == PROTO_TCP) begin
                res.cls = CLS_TCP;
            end else if (proto == PROTO_UDP) begin
                res.cls = CLS_UDP;
            end else if (proto == PROTO_ICMP) begin
                res.cls = CLS_ICMP;
            end else begin
                res.cls = CLS_OTHER;
            end
        end
        return res;
    endfunction

endpackage

// File: design/pctc_cell.sv
`timescale 1ns / 1ps
module pctc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pctc_pkg::t_tok i_tok,
    input  pctc_pkg::t_ctl i_ctl,
    output pctc_pkg::t_tok o_tok
);
    import pctc_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);

    logic        r_active;
    logic [31:0] r_addr;
    logic [31:0] r_pkts;
    logic [31:0] r_bytes;
    t_tok        r_tok;
    t_tok        n_tok;

    logic w_hit_here;
    logic w_free_here;
    logic w_read_here;
    logic w_alloc_here;

    always_comb begin
        w_hit_here   = i_tok.valid && !i_tok.is_read && !i_tok.hit && r_active
                       && (r_addr == i_tok.src);
        w_free_here  = i_tok.valid && !i_tok.is_read && !i_tok.hit && !r_active
                       && !i_tok.have_free;
        w_read_here  = i_tok.valid && i_tok.is_read
                       && ({{(SLOT_W-4){1'b0}}, i_tok.idx} == MY_SLOT);
        w_alloc_here = i_ctl.alloc && (i_ctl.slot == MY_SLOT);

        n_tok = i_tok;
        if (w_hit_here) begin
            n_tok.hit  = 1'b1;
            n_tok.slot = MY_SLOT;
        end else if (w_free_here) begin
            n_tok.have_free = 1'b1;
            n_tok.slot      = MY_SLOT;
        end
        // An inactive entry reads as all zero, so the payload needs no clearing.
        if (w_read_here) begin
            n_tok.ent_valid = r_active;
            n_tok.ent_addr  = r_active ? r_addr  : 32'd0;
            n_tok.ent_pkts  = r_active ? r_pkts  : 32'd0;
            n_tok.ent_bytes = r_active ? r_bytes : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tok    <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_ctl.clear) begin
                r_active <= 1'b0;
            end else if (w_alloc_here) begin
                r_active <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_alloc_here) begin
            r_addr  <= i_ctl.src;
            r_pkts  <= 32'd1;
            r_bytes <= {16'd0, i_ctl.len};
        end else if (w_hit_here) begin
            r_pkts  <= r_pkts + 32'd1;
            r_bytes <= r_bytes + {16'd0, i_tok.len};
        end
    end

    assign o_tok = r_tok;

endmodule

// File: design/packet_class_and_talker_counter_unit.sv
`timescale 1ns / 1ps
// Classifies tracked frames into TCP, UDP, ICMP, ARP or other, keeps window
// packet and byte totals and five class counters, and keeps per-source packet
// and byte counts for up to TALKER_ENTRIES IPv4 talkers. The talker table is
// a row of cells, one entry each, and a lookup or talker read passes one cell
// per clock. A tracked IPv4 frame or a talker read therefore presents its
// result after the launch register, every cell and the output register, and
// with no output stall the next item can be taken while that result leaves.
// Class reads, clears and frames not tracked as talkers present their result
// in the cycle after their transfer and, with no walk in work and no output
// stall, can follow each other in every cycle. One item is in work at a time.
// All counters wrap at 32 bits, and a clear empties every store at once.
module packet_class_and_talker_counter_unit #(
    parameter int TALKER_ENTRIES = pctc_pkg::TALKER_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pctc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pctc_pkg::t_out_item o_out_data
);
    import pctc_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_item   r_out_data;
    t_out_item   n_out_data;
    t_tok        r_launch;
    t_tok        n_launch;
    logic [31:0] r_tot_pkts;
    logic [31:0] r_tot_bytes;
    logic [31:0] r_cls_cnt [NUM_CLASSES];

    t_tok        w_tok [0:TALKER_ENTRIES];
    t_tok        w_end;
    t_ctl        w_ctl;
    t_class_res  w_cls;
    logic        w_acc;
    logic        w_walk;
    logic        w_is_track;
    logic [31:0] w_cls_next;
    logic [31:0] w_cls_read;

    assign w_tok[0] = r_launch;
    assign w_end    = w_tok[TALKER_ENTRIES];

    for (genvar gi = 0; gi < TALKER_ENTRIES; gi++) begin : g_cell
        pctc_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[gi]),
            .i_ctl   (w_ctl),
            .o_tok   (w_tok[gi+1])
        );
    end

    always_comb begin
        w_cls      = classify(i_in_data.frame_length, i_in_data.ether_type,
                              i_in_data.ip_protocol);
        w_is_track = (i_in_data.action == ACT_TRACK);
        w_walk     = (i_in_data.action == ACT_READ_TALKER) || (w_is_track && w_cls.track);
        w_cls_next = r_cls_cnt[w_cls.cls] + 32'd1;
        w_cls_read = (i_in_data.read_index < 4'(NUM_CLASSES))
                     ? r_cls_cnt[i_in_data.read_index[2:0]] : 32'd0;

        // A new item needs the output register free, or freed in this cycle.
        o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
        w_acc      = i_in_valid && !o_in_stall;

        w_ctl.clear = w_acc && (i_in_data.action == ACT_CLEAR);
        w_ctl.alloc = w_end.valid && !w_end.is_read && !w_end.hit && w_end.have_free;
        w_ctl.slot  = w_end.slot;
        w_ctl.src   = w_end.src;
        w_ctl.len   = w_end.len;

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_walk) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_end.valid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if ((w_acc && !w_walk) || w_end.valid) begin
            n_out_valid = 1'b1;
        end

        n_launch       = r_launch;
        n_launch.valid = w_acc && w_walk;
        if (w_acc) begin
            n_launch.is_read   = (i_in_data.action == ACT_READ_TALKER);
            n_launch.src       = i_in_data.source_ip;
            n_launch.len       = i_in_data.frame_length;
            n_launch.idx       = i_in_data.read_index;
            n_launch.hit       = 1'b0;
            n_launch.have_free = 1'b0;
            n_launch.slot      = '0;
            n_launch.ent_valid = 1'b0;
            n_launch.ent_addr  = 32'd0;
            n_launch.ent_pkts  = 32'd0;
            n_launch.ent_bytes = 32'd0;
        end

        n_out_data = r_out_data;
        if (w_acc) begin
            n_out_data = '0;
            unique case (i_in_data.action)
                ACT_TRACK: begin
                    n_out_data.frame_class    = w_cls.cls;
                    n_out_data.class_count    = w_cls_next;
                    n_out_data.window_packets = r_tot_pkts + 32'd1;
                    n_out_data.window_bytes   = r_tot_bytes
                                                + {16'd0, i_in_data.frame_length};
                end
                ACT_READ_TALKER: begin
                    n_out_data.window_packets = r_tot_pkts;
                    n_out_data.window_bytes   = r_tot_bytes;
                end
                ACT_READ_CLASS: begin
                    n_out_data.class_count    = w_cls_read;
                    n_out_data.window_packets = r_tot_pkts;
                    n_out_data.window_bytes   = r_tot_bytes;
                end
                ACT_CLEAR: begin
                    n_out_data.window_packets = 32'd0;
                    n_out_data.window_bytes   = 32'd0;
                end
                default: n_out_data = '0;
            endcase
        end else if (w_end.valid) begin
            if (w_end.is_read) begin
                n_out_data.entry_valid   = w_end.ent_valid;
                n_out_data.entry_address = w_end.ent_addr;
                n_out_data.entry_packets = w_end.ent_pkts;
                n_out_data.entry_bytes   = w_end.ent_bytes;
            end else if (w_end.hit) begin
                n_out_data.talker_status = STS_HIT;
                n_out_data.talker_slot   = w_end.slot[3:0];
            end else if (w_end.have_free) begin
                n_out_data.talker_status = STS_NEW;
                n_out_data.talker_slot   = w_end.slot[3:0];
            end else begin
                n_out_data.talker_status = STS_FULL;
                n_out_data.talker_slot   = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_launch    <= '0;
            r_tot_pkts  <= 32'd0;
            r_tot_bytes <= 32'd0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cls_cnt[k] <= 32'd0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
            r_launch    <= n_launch;
            if (w_ctl.clear) begin
                r_tot_pkts  <= 32'd0;
                r_tot_bytes <= 32'd0;
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    r_cls_cnt[k] <= 32'd0;
                end
            end else if (w_acc && w_is_track) begin
                r_tot_pkts           <= r_tot_pkts + 32'd1;
                r_tot_bytes          <= r_tot_bytes + {16'd0, i_in_data.frame_length};
                r_cls_cnt[w_cls.cls] <= w_cls_next;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/pctc_checker.sv
`timescale 1ns / 1ps
`include "packet_class_and_talker_counter_unit_defines.svh"
module pctc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input pctc_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pctc_pkg::t_out_item o_out_data
);
    import pctc_pkg::*;

    // A held result keeps its transfer open with unchanged contents.
    `PCTC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // No new item is taken while the pending result cannot leave.
    `PCTC_ASSERT_SAME(a_in_blocked, o_out_valid && i_out_stall, o_in_stall, "input open while output blocked")

    `PCTC_ASSERT_SAME(a_class_range, o_out_valid, o_out_data.frame_class <= CLS_OTHER, "frame class out of range")

    // Only a hit or a new entry reports a slot.
    `PCTC_ASSERT_SAME(a_slot_zero, o_out_valid && (o_out_data.talker_status == STS_NONE || o_out_data.talker_status == STS_FULL), o_out_data.talker_slot == 4'd0, "slot set without a talker entry")

endmodule

bind packet_class_and_talker_counter_unit pctc_checker u_pctc_checker (.*);
